// File: hdl/mlrr_pkg.sv
package mlrr_pkg;

    localparam int MAX_EXPERTS_DEF  = 256;
    localparam int MAX_ADAPTERS_DEF = 16;
    localparam int ROW_BITS_DEF     = 24;

    // Item kinds
    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_ROUTE = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_EXPERTS = 2'd0;
    localparam logic [1:0] CFG_NUM_LORAS   = 2'd1;
    localparam logic [1:0] CFG_ADAPTER_MSK = 2'd2;
    localparam logic [1:0] CFG_NUM_ROWS    = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SKIP_RD,
        ST_SKIP_CHK,
        ST_ROUTE_RD,
        ST_ROUTE_WR,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_OUT
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic capture;     // register the input item
        logic clr_start;   // begin histogram clear sweep, reset cursors
        logic clr_step;    // write one zero entry
        logic load;        // apply load item
        logic tbl_rd;      // read group_table at current_expert
        logic skip_apply;  // take table data into rows_left / skip expert
        logic route_rd;    // issue histogram read for routed row
        logic route_fin;   // finish routed row, write histogram, set result
        logic read_rd;     // issue histogram read for query
        logic read_fin;    // latch query result
        logic norows;      // route with no row available: sentinel result
        logic out_load;    // present result
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic clr_last;
        logic func_route;
        logic func_read;
        logic func_start;
        logic in_limit;     // rows_seen < num_rows
        logic need_skip;    // rows_left==0 and an expert remains
        logic out_busy;
    } t_stat;

endpackage

// File: hdl/moe_lora_row_router.sv
// Channel | Direction | Handshake         | Payload
// input   | in        | i_valid / o_stall | i_func, i_group_count, i_slot_bits, i_query_*
// result  | out       | o_valid / i_stall | o_group_id, o_row_enabled, o_lora_count
// config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item at a time. Load: SKIP_CHK. Read: SKIP_CHK, READ_RD, READ_WAIT, OUT. Route:
// SKIP_CHK, then SKIP_RD and SKIP_CHK again per group table entry fetched (each empty
// expert skipped and the next nonempty one), ROUTE_RD, ROUTE_WR, OUT; at or past the
// row limit SKIP_CHK, OUT. Route's histogram update is a single-port read-modify-write.
// After reset and each start the histogram is cleared, one entry a cycle, input stalled.
// A result waits in the output register while o_valid is stalled.
module moe_lora_row_router #(
    parameter int MAX_EXPERTS  = mlrr_pkg::MAX_EXPERTS_DEF,
    parameter int MAX_ADAPTERS = mlrr_pkg::MAX_ADAPTERS_DEF,
    parameter int ROW_BITS     = mlrr_pkg::ROW_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_func,
    input  logic signed [31:0]  i_group_count,
    input  logic [31:0]         i_slot_bits,
    input  logic [3:0]          i_query_lora,
    input  logic [7:0]          i_query_expert,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [12:0]         o_group_id,
    output logic                o_row_enabled,
    output logic [ROW_BITS-1:0] o_lora_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);

    mlrr_pkg::t_cmd  w_cmd;
    mlrr_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    mlrr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    mlrr_dp #(
        .MAX_EXPERTS  (MAX_EXPERTS),
        .MAX_ADAPTERS (MAX_ADAPTERS),
        .ROW_BITS     (ROW_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_group_count  (i_group_count),
        .i_slot_bits    (i_slot_bits),
        .i_query_lora   (i_query_lora),
        .i_query_expert (i_query_expert),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_group_id     (o_group_id),
        .o_row_enabled  (o_row_enabled),
        .o_lora_count   (o_lora_count)
    );

endmodule

// File: hdl/mlrr_ctrl.sv
module mlrr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  mlrr_pkg::t_stat i_stat,
    output mlrr_pkg::t_cmd  o_cmd
);

    mlrr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlrr_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mlrr_pkg::ST_CLEAR: begin
                if (i_stat.clr_last) n_state = mlrr_pkg::ST_IDLE;
            end
            mlrr_pkg::ST_IDLE: begin
                if (i_valid) n_state = mlrr_pkg::ST_SKIP_CHK;
            end
            mlrr_pkg::ST_SKIP_CHK: begin
                if (i_stat.func_start) n_state = mlrr_pkg::ST_CLEAR;
                else if (i_stat.func_read) n_state = mlrr_pkg::ST_READ_RD;
                else if (!i_stat.func_route) n_state = mlrr_pkg::ST_IDLE;
                else if (!i_stat.in_limit) n_state = mlrr_pkg::ST_OUT;
                else if (i_stat.need_skip) n_state = mlrr_pkg::ST_SKIP_RD;
                else n_state = mlrr_pkg::ST_ROUTE_RD;
            end
            mlrr_pkg::ST_SKIP_RD:   n_state = mlrr_pkg::ST_SKIP_CHK;
            mlrr_pkg::ST_ROUTE_RD:  n_state = mlrr_pkg::ST_ROUTE_WR;
            mlrr_pkg::ST_ROUTE_WR:  n_state = mlrr_pkg::ST_OUT;
            mlrr_pkg::ST_READ_RD:   n_state = mlrr_pkg::ST_READ_WAIT;
            mlrr_pkg::ST_READ_WAIT: n_state = mlrr_pkg::ST_OUT;
            mlrr_pkg::ST_OUT: begin
                if (!i_stat.out_busy) n_state = mlrr_pkg::ST_IDLE;
            end
            default: n_state = mlrr_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            mlrr_pkg::ST_CLEAR: o_cmd.clr_step = 1'b1;
            mlrr_pkg::ST_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            mlrr_pkg::ST_SKIP_CHK: begin
                if (i_stat.func_start) o_cmd.clr_start = 1'b1;
                else if (!i_stat.func_route && !i_stat.func_read) o_cmd.load = 1'b1;
                else if (i_stat.func_route && !i_stat.in_limit) o_cmd.norows = 1'b1;
                else if (i_stat.func_route && i_stat.need_skip) o_cmd.tbl_rd = 1'b1;
                else if (i_stat.func_route) o_cmd.route_rd = 1'b1;
            end
            mlrr_pkg::ST_SKIP_RD:   o_cmd.skip_apply = 1'b1;
            mlrr_pkg::ST_ROUTE_WR:  o_cmd.route_fin  = 1'b1;
            mlrr_pkg::ST_READ_RD:   o_cmd.read_rd    = 1'b1;
            mlrr_pkg::ST_READ_WAIT: o_cmd.read_fin   = 1'b1;
            mlrr_pkg::ST_OUT: begin
                o_cmd.out_load = !i_stat.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: hdl/mlrr_dp.sv
module mlrr_dp #(
    parameter int MAX_EXPERTS  = mlrr_pkg::MAX_EXPERTS_DEF,
    parameter int MAX_ADAPTERS = mlrr_pkg::MAX_ADAPTERS_DEF,
    parameter int ROW_BITS     = mlrr_pkg::ROW_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mlrr_pkg::t_cmd      i_cmd,
    output mlrr_pkg::t_stat     o_stat,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data,
    input  logic [1:0]          i_func,
    input  logic signed [31:0]  i_group_count,
    input  logic [31:0]         i_slot_bits,
    input  logic [3:0]          i_query_lora,
    input  logic [7:0]          i_query_expert,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [12:0]         o_group_id,
    output logic                o_row_enabled,
    output logic [ROW_BITS-1:0] o_lora_count
);

    localparam int EW = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
    localparam int PW = $clog2(MAX_EXPERTS + 1);
    localparam int AW = $clog2(MAX_ADAPTERS + 1);
    localparam int HD = MAX_EXPERTS * MAX_ADAPTERS;
    localparam int HW = (HD > 1) ? $clog2(HD) : 1;
    localparam int GW = $clog2(HD + 1);
    localparam logic [ROW_BITS-1:0] ROW_MAX = '1;

    // Configuration registers
    logic [8:0]  r_num_experts;
    logic [4:0]  r_num_loras;
    logic [15:0] r_adapter_mask;
    logic [23:0] r_num_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_experts  <= 9'd1;
            r_num_loras    <= 5'd1;
            r_adapter_mask <= '0;
            r_num_rows     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mlrr_pkg::CFG_NUM_EXPERTS: r_num_experts  <= i_cfg_data[8:0];
                mlrr_pkg::CFG_NUM_LORAS:   r_num_loras    <= i_cfg_data[4:0];
                mlrr_pkg::CFG_ADAPTER_MSK: r_adapter_mask <= i_cfg_data[15:0];
                default:                   r_num_rows     <= i_cfg_data;
            endcase
        end
    end

    // Clamped counts
    logic [PW-1:0] w_ne;
    logic [AW-1:0] w_nl;
    logic [GW-1:0] w_sentinel;
    always_comb begin
        if (r_num_experts == 9'd0) w_ne = PW'(1);
        else if (32'(r_num_experts) > MAX_EXPERTS) w_ne = PW'(MAX_EXPERTS);
        else w_ne = PW'(r_num_experts);
        if (r_num_loras == 5'd0) w_nl = AW'(1);
        else if (32'(r_num_loras) > MAX_ADAPTERS) w_nl = AW'(MAX_ADAPTERS);
        else w_nl = AW'(r_num_loras);
    end

    // Sentinel product registered once the registers settle
    logic [GW-1:0] r_sentinel;
    always_ff @(posedge i_clk) r_sentinel <= GW'(w_nl) * GW'(w_ne);
    assign w_sentinel = r_sentinel;

    // Captured item
    logic [1:0]  r_func;
    logic [31:0] r_gc;
    logic [31:0] r_slot;
    logic [3:0]  r_ql;
    logic [7:0]  r_qe;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_gc   <= i_group_count;
            r_slot <= i_slot_bits;
            r_ql   <= i_query_lora;
            r_qe   <= i_query_expert;
        end
    end

    // Cursors
    logic [PW-1:0]       r_load_ptr, r_cur;
    logic [ROW_BITS-1:0] r_rows_left;
    logic [23:0]         r_rows_seen;
    logic [HW-1:0]       r_clr_addr;

    // Group table memory
    logic [ROW_BITS-1:0] r_tbl [MAX_EXPERTS];
    logic [ROW_BITS-1:0] r_tbl_q;
    logic [ROW_BITS-1:0] w_load_cnt;
    always_comb begin
        if (r_gc[31]) w_load_cnt = '0;
        else if ({1'b0, r_gc} > 33'(ROW_MAX)) w_load_cnt = ROW_MAX;
        else w_load_cnt = r_gc[ROW_BITS-1:0];
    end
    logic w_load_ok;
    assign w_load_ok = (r_load_ptr < w_ne);
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_load_ok) r_tbl[r_load_ptr[EW-1:0]] <= w_load_cnt;
        if (i_cmd.tbl_rd) r_tbl_q <= r_tbl[r_cur[EW-1:0]];
    end

    // Float slot decode: value in [0, nl) with -0.0 as slot 0
    logic [7:0]  w_exp;
    logic        w_slot_ok;
    logic [3:0]  w_slot;
    logic [22:0] w_man;
    always_comb begin
        w_exp = r_slot[30:23];
        w_man = r_slot[22:0];
        w_slot_ok = 1'b0;
        w_slot = '0;
        if (w_exp < 8'd127) begin
            // zero, denormal or below one: slot 0 (negatives only as zero)
            w_slot_ok = !r_slot[31] || (r_slot[30:0] == 31'd0);
            w_slot = 4'd0;
        end else if (w_exp <= 8'd130 && !r_slot[31]) begin
            w_slot_ok = 1'b1;
            w_slot = 4'(({1'b1, w_man[22:20]}) >> (3 - (w_exp - 8'd127)));
        end
        // truncated value must be below nl
        if (w_slot_ok && (5'(w_slot) >= 5'(w_nl))) w_slot_ok = 1'b0;
        if (w_slot_ok && !r_adapter_mask[w_slot]) w_slot_ok = 1'b0;
    end

    // Histogram memory
    logic [ROW_BITS-1:0] r_hist [HD];
    logic [ROW_BITS-1:0] r_hist_q;
    logic [HW-1:0]       r_hidx;
    logic                r_hit;
    logic [HW-1:0]       w_ridx, w_qidx;
    logic [GW-1:0]       w_rprod;
    assign w_rprod = GW'(w_slot) * GW'(w_ne) + GW'(r_cur);
    assign w_ridx  = HW'(w_rprod);
    assign w_qidx  = HW'(GW'(r_ql) * GW'(w_ne) + GW'(r_qe));
    logic w_q_ok;
    assign w_q_ok = (5'(r_ql) < 5'(w_nl)) && (PW'(r_qe) < w_ne);

    always_ff @(posedge i_clk) begin
        if (i_cmd.route_rd) r_hidx <= w_ridx;
        else if (i_cmd.read_rd) r_hidx <= w_qidx;
        if (i_cmd.route_rd || i_cmd.read_rd) r_hist_q <= r_hist[i_cmd.route_rd ? w_ridx : w_qidx];
        if (i_cmd.clr_step) r_hist[r_clr_addr] <= '0;
        else if (i_cmd.route_fin && r_hit && r_hist_q != ROW_MAX)
            r_hist[r_hidx] <= r_hist_q + 1'b1;
    end

    // Cursor and clear control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_ptr  <= '0;
            r_cur       <= '0;
            r_rows_left <= '0;
            r_rows_seen <= '0;
            r_clr_addr  <= '0;
            r_hit       <= 1'b0;
        end else begin
            if (i_cmd.clr_start) begin
                r_load_ptr  <= '0;
                r_cur       <= '0;
                r_rows_left <= '0;
                r_rows_seen <= '0;
                r_clr_addr  <= '0;
            end
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.load && w_load_ok) r_load_ptr <= r_load_ptr + 1'b1;
            if (i_cmd.skip_apply) begin
                if (r_tbl_q == '0) r_cur <= r_cur + 1'b1;
                r_rows_left <= r_tbl_q;
            end
            if (i_cmd.route_rd) begin
                r_rows_seen <= r_rows_seen + 1'b1;
                r_hit <= (r_rows_left != '0) && w_slot_ok;
                if (r_rows_left != '0) begin
                    r_rows_left <= r_rows_left - 1'b1;
                    if (r_rows_left == ROW_BITS'(1)) r_cur <= r_cur + 1'b1;
                end
            end
        end
    end

    // Result staging
    logic [12:0]         r_res_gid;
    logic                r_res_en;
    logic [ROW_BITS-1:0] r_res_cnt;
    always_ff @(posedge i_clk) begin
        if (i_cmd.norows) begin
            r_res_gid <= 13'(w_sentinel);
            r_res_en  <= 1'b0;
            r_res_cnt <= '0;
        end else if (i_cmd.route_fin) begin
            r_res_gid <= r_hit ? 13'(r_hidx) : 13'(w_sentinel);
            r_res_en  <= r_hit;
            r_res_cnt <= '0;
        end else if (i_cmd.read_fin) begin
            r_res_gid <= '0;
            r_res_en  <= 1'b0;
            r_res_cnt <= w_q_ok ? r_hist_q : '0;
        end
    end

    // Output register
    logic r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_group_id    <= r_res_gid;
            o_row_enabled <= r_res_en;
            o_lora_count  <= r_res_cnt;
        end
    end
    assign o_valid = r_valid;

    // Status
    always_comb begin
        o_stat.clr_last   = (r_clr_addr == HW'(HD - 1));
        o_stat.func_route = (r_func == mlrr_pkg::FUNC_ROUTE);
        o_stat.func_read  = (r_func == mlrr_pkg::FUNC_READ);
        o_stat.func_start = (r_func == mlrr_pkg::FUNC_START);
        o_stat.in_limit   = (r_rows_seen < r_num_rows);
        o_stat.need_skip  = (r_rows_left == '0) && (r_cur < r_load_ptr) && (r_cur < w_ne);
        o_stat.out_busy   = r_valid && i_stall;
    end

endmodule
